// ===== src/lrut_pkg.sv =====
package lrut_pkg;

  // Fixed field widths of the request, response and configuration ports.
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned STATUS_W = 2;

  // Reset value of the entries-in-use register.
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Request operation codes.
  localparam logic OP_PIN = 1'b1;

  // Response status codes.
  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_HIT   = 2'd0;
  localparam status_t ST_ALLOC = 2'd1;
  localparam status_t ST_NONE  = 2'd2;
  localparam status_t ST_PIN   = 2'd3;

endpackage

// ===== src/lrut_req_if.sv =====
interface lrut_req_if;

  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [lrut_pkg::KEY_W-1:0]  key;
  logic [lrut_pkg::IDX_W-1:0]  entry_sel;
  logic                        pin_value;

  modport source (output valid, op, key, entry_sel, pin_value, input ready);
  modport sink   (input valid, op, key, entry_sel, pin_value, output ready);

endinterface

// ===== src/lrut_rsp_if.sv =====
interface lrut_rsp_if;

  logic                        valid;
  logic                        ready;
  lrut_pkg::status_t           status;
  logic [lrut_pkg::IDX_W-1:0]  entry_index;
  logic                        displaced_valid;
  logic [lrut_pkg::KEY_W-1:0]  displaced_key;

  modport source (output valid, status, entry_index, displaced_valid, displaced_key,
                  input ready);
  modport sink   (input valid, status, entry_index, displaced_valid, displaced_key,
                  output ready);

endinterface

// ===== src/lru_tag_table_with_pinning_top.sv =====
// Fully associative tag table with least-recently-used replacement and per-entry
// pin flags. A lookup (op 0) is handled by one shared compare unit that walks the
// entries in use, one per cycle, reading the tag and recency memories, to find a hit or
// the least recent unpinned victim. A hit or an allocation then runs a recency update
// sweep over all ENTRIES entries through the read and write ports of the recency memory,
// followed by the S_FIN state, which hands the result to the output register once that
// register is free. A lookup that finds every entry pinned skips the sweep, and a pin
// write skips both the scan and the sweep. Requests are accepted only while the
// sequencer is idle, but a finished response may wait in the output register
// while the next request is being processed. Valid, pin and recency-initialised
// flags are flip-flops cleared by reset, so no clearing pass is needed.
module lru_tag_table_with_pinning_top #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrut_pkg::CFG_W-1:0]    cfg_wdata_i,
  lrut_req_if.sink                      req_i,
  lrut_rsp_if.source                    rsp_o
);

  import lrut_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SWEEP,
    S_FIN
  } state_e;

  state_e               state_q, state_d;
  logic [CFG_W-1:0]     cfg_q, cfg_d;
  logic [CW-1:0]        n_q, n_d, n_clamp;
  logic [KEY_BITS-1:0]  key_q, key_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [IW-1:0]        chk_q, chk_d;
  logic                 found_q, found_d;
  logic [IW-1:0]        vic_q, vic_d;
  logic [IW-1:0]        best_q, best_d;
  logic [KEY_BITS-1:0]  vkey_q, vkey_d;
  logic                 vdv_q, vdv_d;
  logic [IW-1:0]        tgt_q, tgt_d;
  logic [IW-1:0]        tgt_rank_q, tgt_rank_d;
  status_t              res_status_q, res_status_d;
  logic [IDX_W-1:0]     res_idx_q, res_idx_d;
  logic                 res_dv_q, res_dv_d;
  logic [KEY_W-1:0]     res_dk_q, res_dk_d;
  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic [ENTRIES-1:0]   pin_q, pin_d;
  logic [ENTRIES-1:0]   rinit_q, rinit_d;
  logic                 out_valid_q, out_valid_d;
  status_t              out_status_q, out_status_d;
  logic [IDX_W-1:0]     out_idx_q, out_idx_d;
  logic                 out_dv_q, out_dv_d;
  logic [KEY_W-1:0]     out_dk_q, out_dk_d;

  // Memories and their ports.
  logic [KEY_BITS-1:0]  tag_mem [ENTRIES];
  logic [IW-1:0]        rank_mem [ENTRIES];
  logic [KEY_BITS-1:0]  tag_rd_q;
  logic [IW-1:0]        rank_rd_q;
  logic [IW-1:0]        rd_addr;
  logic                 tag_we;
  logic [IW-1:0]        tag_waddr;
  logic                 rank_we;
  logic [IW-1:0]        rank_wdata;

  // Shared compare unit signals.
  logic [IW-1:0]        rank_eff;
  logic                 hit;
  logic                 cand;
  logic                 last;
  logic [IW-1:0]        fin_vic;
  logic [IW-1:0]        fin_rank;
  logic [KEY_BITS-1:0]  fin_key;
  logic                 fin_dv;

  // Out-of-range register values act as the nearest legal entry count.
  always_comb begin
    if (cfg_q == '0) begin
      n_clamp = CW'(1);
    end else if (32'(cfg_q) > ENTRIES) begin
      n_clamp = CW'(ENTRIES);
    end else begin
      n_clamp = CW'(cfg_q);
    end
  end

  // An entry whose rank was never written holds its reset rank, its own index.
  assign rank_eff = rinit_q[chk_q] ? rank_rd_q : chk_q;

  assign hit  = valid_q[chk_q] && (tag_rd_q == key_q);
  assign cand = !pin_q[chk_q] && (!found_q || (rank_eff > best_q));
  assign last = (CW'(chk_q) == (n_q - CW'(1)));

  assign fin_vic  = cand ? chk_q : vic_q;
  assign fin_rank = cand ? rank_eff : best_q;
  assign fin_key  = cand ? tag_rd_q : vkey_q;
  assign fin_dv   = cand ? valid_q[chk_q] : vdv_q;

  assign req_i.ready = (state_q == S_IDLE);

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.entry_index     = out_idx_q;
  assign rsp_o.displaced_valid = out_dv_q;
  assign rsp_o.displaced_key   = out_dk_q;

  // Sequencer next-state logic.
  always_comb begin
    state_d      = state_q;
    cfg_d        = cfg_q;
    n_d          = n_q;
    key_d        = key_q;
    cnt_d        = cnt_q;
    chk_vld_d    = chk_vld_q;
    chk_d        = chk_q;
    found_d      = found_q;
    vic_d        = vic_q;
    best_d       = best_q;
    vkey_d       = vkey_q;
    vdv_d        = vdv_q;
    tgt_d        = tgt_q;
    tgt_rank_d   = tgt_rank_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    res_dv_d     = res_dv_q;
    res_dk_d     = res_dk_q;
    valid_d      = valid_q;
    pin_d        = pin_q;
    rinit_d      = rinit_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_idx_d    = out_idx_q;
    out_dv_d     = out_dv_q;
    out_dk_d     = out_dk_q;
    rd_addr      = cnt_q[IW-1:0];
    tag_we       = 1'b0;
    tag_waddr    = fin_vic;
    rank_we      = 1'b0;
    rank_wdata   = rank_eff;

    if (cfg_we_i) begin
      cfg_d = cfg_wdata_i;
    end

    // The output register empties on a transfer.
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.op == OP_PIN) begin
            if (32'(req_i.entry_sel) < ENTRIES) begin
              pin_d[IW'(req_i.entry_sel)] = req_i.pin_value;
            end
            res_status_d = ST_PIN;
            res_idx_d    = req_i.entry_sel;
            res_dv_d     = 1'b0;
            res_dk_d     = '0;
            state_d      = S_FIN;
          end else begin
            key_d     = KEY_BITS'(req_i.key);
            n_d       = n_clamp;
            cnt_d     = '0;
            chk_vld_d = 1'b0;
            found_d   = 1'b0;
            state_d   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous entry is being compared.
        if (cnt_q < n_q) begin
          cnt_d     = cnt_q + CW'(1);
          chk_vld_d = 1'b1;
          chk_d     = cnt_q[IW-1:0];
        end else begin
          chk_vld_d = 1'b0;
        end

        if (chk_vld_q) begin
          if (hit) begin
            tgt_d        = chk_q;
            tgt_rank_d   = rank_eff;
            res_status_d = ST_HIT;
            res_idx_d    = IDX_W'(chk_q);
            res_dv_d     = 1'b0;
            res_dk_d     = '0;
            cnt_d        = '0;
            chk_vld_d    = 1'b0;
            state_d      = S_SWEEP;
          end else begin
            if (cand) begin
              found_d = 1'b1;
              vic_d   = chk_q;
              best_d  = rank_eff;
              vkey_d  = tag_rd_q;
              vdv_d   = valid_q[chk_q];
            end
            if (last) begin
              if (found_q || cand) begin
                // Retag the victim and make it most recent in the sweep.
                tag_we          = 1'b1;
                valid_d[fin_vic] = 1'b1;
                pin_d[fin_vic]   = 1'b0;
                tgt_d           = fin_vic;
                tgt_rank_d      = fin_rank;
                res_status_d    = ST_ALLOC;
                res_idx_d       = IDX_W'(fin_vic);
                res_dv_d        = fin_dv;
                res_dk_d        = fin_dv ? KEY_W'(fin_key) : '0;
                cnt_d           = '0;
                chk_vld_d       = 1'b0;
                state_d         = S_SWEEP;
              end else begin
                res_status_d = ST_NONE;
                res_idx_d    = '0;
                res_dv_d     = 1'b0;
                res_dk_d     = '0;
                chk_vld_d    = 1'b0;
                state_d      = S_FIN;
              end
            end
          end
        end
      end

      S_SWEEP: begin
        // Read-modify-write of every rank, one entry per cycle.
        if (cnt_q < CW'(ENTRIES)) begin
          cnt_d     = cnt_q + CW'(1);
          chk_vld_d = 1'b1;
          chk_d     = cnt_q[IW-1:0];
        end else begin
          chk_vld_d = 1'b0;
        end

        if (chk_vld_q) begin
          rank_we        = 1'b1;
          rinit_d[chk_q] = 1'b1;
          if (chk_q == tgt_q) begin
            rank_wdata = '0;
          end else if (rank_eff < tgt_rank_q) begin
            rank_wdata = rank_eff + IW'(1);
          end else begin
            rank_wdata = rank_eff;
          end
          if (chk_q == IW'(ENTRIES - 1)) begin
            chk_vld_d = 1'b0;
            state_d   = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_idx_d    = res_idx_q;
          out_dv_d     = res_dv_q;
          out_dk_d     = res_dk_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cfg_q        <= CFG_RESET;
      n_q          <= '0;
      key_q        <= '0;
      cnt_q        <= '0;
      chk_vld_q    <= 1'b0;
      chk_q        <= '0;
      found_q      <= 1'b0;
      vic_q        <= '0;
      best_q       <= '0;
      vkey_q       <= '0;
      vdv_q        <= 1'b0;
      tgt_q        <= '0;
      tgt_rank_q   <= '0;
      res_status_q <= ST_HIT;
      res_idx_q    <= '0;
      res_dv_q     <= 1'b0;
      res_dk_q     <= '0;
      valid_q      <= '0;
      pin_q        <= '0;
      rinit_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_HIT;
      out_idx_q    <= '0;
      out_dv_q     <= 1'b0;
      out_dk_q     <= '0;
    end else begin
      state_q      <= state_d;
      cfg_q        <= cfg_d;
      n_q          <= n_d;
      key_q        <= key_d;
      cnt_q        <= cnt_d;
      chk_vld_q    <= chk_vld_d;
      chk_q        <= chk_d;
      found_q      <= found_d;
      vic_q        <= vic_d;
      best_q       <= best_d;
      vkey_q       <= vkey_d;
      vdv_q        <= vdv_d;
      tgt_q        <= tgt_d;
      tgt_rank_q   <= tgt_rank_d;
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
      res_dv_q     <= res_dv_d;
      res_dk_q     <= res_dk_d;
      valid_q      <= valid_d;
      pin_q        <= pin_d;
      rinit_q      <= rinit_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_idx_q    <= out_idx_d;
      out_dv_q     <= out_dv_d;
      out_dk_q     <= out_dk_d;
    end
  end

  // Tag memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= key_q;
    end
    tag_rd_q <= tag_mem[rd_addr];
  end

  // Recency memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (rank_we) begin
      rank_mem[chk_q] <= rank_wdata;
    end
    rank_rd_q <= rank_mem[rd_addr];
  end

endmodule

// ===== src/lrut_checker.sv =====
module lrut_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  lrut_pkg::status_t             rsp_status_i,
  input  logic [lrut_pkg::IDX_W-1:0]    rsp_entry_index_i,
  input  logic                          rsp_displaced_valid_i,
  input  logic [lrut_pkg::KEY_W-1:0]    rsp_displaced_key_i
);

  import lrut_pkg::*;

  // A stalled response holds its contents.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i)
      && $stable(rsp_entry_index_i) && $stable(rsp_displaced_valid_i)
      && $stable(rsp_displaced_key_i))
    else $error("response changed while stalled");

  // The block is busy in the cycle after it takes a request.
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one still in progress");

  // Only an allocation may report a displaced key.
  a_displaced_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_displaced_valid_i |-> rsp_status_i == ST_ALLOC)
    else $error("displaced key reported without allocation");

  // A pin write reports no displaced key.
  a_pin_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_PIN |->
      !rsp_displaced_valid_i && rsp_displaced_key_i == '0)
    else $error("pin response carries a displaced key");

  // A failed allocation reports entry zero and no displaced key.
  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == ST_NONE |->
      rsp_entry_index_i == '0 && rsp_displaced_key_i == '0)
    else $error("failed allocation carries entry or key");

endmodule

bind lru_tag_table_with_pinning_top lrut_checker u_lrut_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .req_valid_i           (req_i.valid),
  .req_ready_i           (req_i.ready),
  .rsp_valid_i           (rsp_o.valid),
  .rsp_ready_i           (rsp_o.ready),
  .rsp_status_i          (rsp_o.status),
  .rsp_entry_index_i     (rsp_o.entry_index),
  .rsp_displaced_valid_i (rsp_o.displaced_valid),
  .rsp_displaced_key_i   (rsp_o.displaced_key)
);

// ===== bench/tb.sv =====
module tb;
  import lrut_pkg::*;

  localparam int unsigned ENTRIES      = 16;
  localparam logic        OP_LOOKUP    = ~OP_PIN;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE_TICKS = 2 * ENTRIES + 8;
  localparam int unsigned KEY_POOL     = 24;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] entry_sel;
    logic             pin_value;
  } table_req_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] entry_index;
    logic             displaced_valid;
    logic [KEY_W-1:0] displaced_key;
  } table_rsp_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  lrut_req_if req_if ();
  lrut_rsp_if rsp_if ();

  lru_tag_table_with_pinning_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Shadow copy of the tag table: keys, valid and pin flags, recency ranks (0 is newest).
  logic [KEY_W-1:0] shadow_tag [ENTRIES];
  logic [ENTRIES-1:0] shadow_valid;
  logic [ENTRIES-1:0] shadow_pin;
  int unsigned        shadow_rank [ENTRIES];
  logic [CFG_W-1:0]   shadow_in_use;

  table_req_t  request_backlog [$];
  table_rsp_t  outcomes_due [$];

  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned failures;
  int unsigned cycle_count;
  int unsigned hit_count;
  int unsigned alloc_count;
  int unsigned evict_count;
  int unsigned refusal_count;
  int unsigned pin_count;
  int unsigned setting_count;

  always #5 clk_i = ~clk_i;

  // Entries taking part in lookup; the register saturates at both ends.
  function automatic int unsigned active_entries();
    if (shadow_in_use == 0) return 1;
    if (shadow_in_use > ENTRIES) return ENTRIES;
    return 32'(shadow_in_use);
  endfunction

  function automatic void make_newest(int unsigned e);
    int unsigned r;
    r = shadow_rank[e];
    for (int i = 0; i < ENTRIES; i++) begin
      if (shadow_rank[i] < r) shadow_rank[i]++;
    end
    shadow_rank[e] = 0;
  endfunction

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic table_rsp_t table_outcome(table_req_t rq);
    table_rsp_t  rs;
    int unsigned n;
    int unsigned victim;
    bit          found;
    rs = '0;
    if (rq.op == OP_PIN) begin
      shadow_pin[rq.entry_sel] = rq.pin_value;
      rs.status      = ST_PIN;
      rs.entry_index = rq.entry_sel;
      return rs;
    end
    n = active_entries();
    // The lowest matching valid entry wins, pinned or not.
    for (int i = 0; i < n; i++) begin
      if (shadow_valid[i] && shadow_tag[i] == rq.key) begin
        make_newest(i);
        rs.status      = ST_HIT;
        rs.entry_index = IDX_W'(i);
        return rs;
      end
    end
    // Miss: the oldest unpinned entry is replaced, valid or not.
    found  = 1'b0;
    victim = 0;
    for (int i = 0; i < n; i++) begin
      if (!shadow_pin[i] && (!found || shadow_rank[i] > shadow_rank[victim])) begin
        victim = i;
        found  = 1'b1;
      end
    end
    if (!found) begin
      rs.status = ST_NONE;
      return rs;
    end
    rs.status          = ST_ALLOC;
    rs.entry_index     = IDX_W'(victim);
    rs.displaced_valid = shadow_valid[victim];
    rs.displaced_key   = shadow_valid[victim] ? shadow_tag[victim] : '0;
    shadow_tag[victim]   = rq.key;
    shadow_valid[victim] = 1'b1;
    shadow_pin[victim]   = 1'b0;
    make_newest(victim);
    return rs;
  endfunction

  function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
      failures++;
    end
  endfunction

  function automatic void push_lookup(logic [KEY_W-1:0] key);
    table_req_t rq;
    rq           = '0;
    rq.op        = OP_LOOKUP;
    rq.key       = key;
    request_backlog.push_back(rq);
  endfunction

  function automatic void push_pin(logic [IDX_W-1:0] sel, logic value);
    table_req_t rq;
    rq           = '0;
    rq.op        = OP_PIN;
    rq.entry_sel = sel;
    rq.pin_value = value;
    request_backlog.push_back(rq);
  endfunction

  // Request driver: predicts each accepted transfer and offers the next one.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    table_req_t taken;
    table_req_t nxt;
    table_rsp_t outcome;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken.op        = req_if.op;
        taken.key       = req_if.key;
        taken.entry_sel = req_if.entry_sel;
        taken.pin_value = req_if.pin_value;
        outcome = table_outcome(taken);
        outcomes_due.push_back(outcome);
        case (outcome.status)
          ST_HIT:   hit_count++;
          ST_ALLOC: begin
            alloc_count++;
            if (outcome.displaced_valid) evict_count++;
          end
          ST_NONE:  refusal_count++;
          default:  pin_count++;
        endcase
      end
      if (!req_if.valid || req_if.ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = request_backlog.pop_front();
          req_if.valid     <= 1'b1;
          req_if.op        <= nxt.op;
          req_if.key       <= nxt.key;
          req_if.entry_sel <= nxt.entry_sel;
          req_if.pin_value <= nxt.pin_value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compares every transfer with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : response_monitor
    table_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (outcomes_due.size() == 0) begin
          $error("unexpected response transfer: status %0d entry %0d",
                 rsp_if.status, rsp_if.entry_index);
          failures++;
        end else begin
          want = outcomes_due.pop_front();
          check_field("status", KEY_W'(want.status), KEY_W'(rsp_if.status));
          check_field("entry_index", KEY_W'(want.entry_index),
                      KEY_W'(rsp_if.entry_index));
          check_field("displaced_valid", KEY_W'(want.displaced_valid),
                      KEY_W'(rsp_if.displaced_valid));
          check_field("displaced_key", want.displaced_key, rsp_if.displaced_key);
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, outcomes_due.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  // Writes the entries-in-use register; only called with the table idle.
  task automatic set_entries(input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_in_use = value;
    setting_count++;
  endtask

  // Waits until every queued request has been sent and answered, then lets the table settle.
  task automatic drain();
    do @(negedge clk_i);
    while (request_backlog.size() != 0 || req_if.valid || outcomes_due.size() != 0);
    repeat (SETTLE_TICKS) @(posedge clk_i);
  endtask

  // Mostly lookups from a small key pool sized to the active entries, with pin writes mixed in.
  task automatic random_phase(input logic [CFG_W-1:0] in_use, input int unsigned gap,
                              input int unsigned stall, input int unsigned count);
    logic [KEY_W-1:0] keys [KEY_POOL];
    int unsigned      n;
    int unsigned      span;
    table_req_t       rq;
    set_entries(in_use);
    @(negedge clk_i);
    send_gap_pct = gap;
    stall_pct    = stall;
    n    = active_entries();
    span = n + $urandom_range(1, 4);
    if (span > KEY_POOL) span = KEY_POOL;
    foreach (keys[k]) keys[k] = $urandom();
    for (int j = 0; j < count; j++) begin
      rq.entry_sel = IDX_W'($urandom());
      rq.pin_value = 1'($urandom());
      rq.key       = $urandom();
      if ($urandom_range(99) < 20) begin
        rq.op = OP_PIN;
        if ($urandom_range(3) != 0) rq.entry_sel = IDX_W'($urandom_range(n - 1));
        rq.pin_value = ($urandom_range(99) < 45);
      end else begin
        rq.op = OP_LOOKUP;
        if ($urandom_range(9) != 0) rq.key = keys[$urandom_range(span - 1)];
      end
      request_backlog.push_back(rq);
    end
    drain();
  endtask

  initial begin : stimulus
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    req_if.valid     = 1'b0;
    req_if.op        = OP_LOOKUP;
    req_if.key       = '0;
    req_if.entry_sel = '0;
    req_if.pin_value = 1'b0;
    rsp_if.ready     = 1'b0;
    send_gap_pct     = 0;
    stall_pct        = 0;
    failures         = 0;
    cycle_count      = 0;
    hit_count        = 0;
    alloc_count      = 0;
    evict_count      = 0;
    refusal_count    = 0;
    pin_count        = 0;
    setting_count    = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_tag[i]  = '0;
      shadow_rank[i] = i;
    end
    shadow_valid  = '0;
    shadow_pin    = '0;
    shadow_in_use = CFG_RESET;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Two entries: fill, hit, displace, refuse when both are pinned, hit a pinned entry.
    set_entries(2);
    @(negedge clk_i);
    push_lookup('0);
    push_lookup('1);
    push_lookup('0);
    push_lookup(32'hA5A5_A5A5);
    push_pin(0, 1'b1);
    push_pin(1, 1'b1);
    push_lookup(32'h1234_5678);
    push_lookup('0);
    push_pin(IDX_W'(ENTRIES - 1), 1'b1);
    push_pin(IDX_W'(ENTRIES - 1), 1'b0);
    push_pin(1, 1'b0);
    push_lookup(32'h1234_5678);
    drain();

    // Shrink to one entry and retag it, leaving one key in two entries once regrown.
    set_entries(1);
    @(negedge clk_i);
    push_pin(0, 1'b0);
    push_lookup(32'h1234_5678);
    drain();
    set_entries(2);
    @(negedge clk_i);
    push_lookup(32'h1234_5678);
    push_lookup(32'h5A5A_5A5A);
    drain();

    // Random traffic over a range of table sizes and idling patterns.
    random_phase(16, 0, 0, 500);
    random_phase(0, 85, 0, 100);
    random_phase(31, 0, 85, 400);
    random_phase(3, 38, 38, 300);
    random_phase(8, 0, 0, 300);
    random_phase(1, 0, 85, 100);
    random_phase(16, 38, 38, 300);

    $display("%0d lookups: %0d hits, %0d allocations (%0d evicting a key), %0d refused",
             hit_count + alloc_count + refusal_count, hit_count, alloc_count,
             evict_count, refusal_count);
    $display("%0d pin writes over %0d table sizes, %0d cycles",
             pin_count, setting_count, cycle_count);
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
